// ----- src/fdl_pkg.sv -----
package fdl_pkg;

  localparam int unsigned SAMPLE_WIDTH  = 16;
  localparam int unsigned WORD_WIDTH    = 32;
  localparam int unsigned Q_SHIFT       = 16;
  localparam int unsigned CFG_WIDTH     = 32;
  localparam int unsigned CFG_IDX_WIDTH = 3;

  localparam int unsigned LEN_WIDTH      = 19;
  localparam int unsigned PRESCALE_WIDTH = 32;
  localparam int unsigned DRY_WIDTH      = 20;
  localparam int unsigned WET_WIDTH      = 18;
  localparam int unsigned FB_WIDTH       = 18;

  localparam logic [LEN_WIDTH-1:0]      LEN_RESET      = 19'd1;
  localparam logic [PRESCALE_WIDTH-1:0] PRESCALE_RESET = 32'd32768;
  localparam logic [DRY_WIDTH-1:0]      DRY_RESET      = 20'd131072;
  localparam logic [WET_WIDTH-1:0]      WET_RESET      = 18'd0;
  localparam logic [FB_WIDTH-1:0]       FB_RESET       = 18'd0;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_DELAY_LENGTH  = 3'd0,
    CFG_PRESCALE_GAIN = 3'd1,
    CFG_DRY_GAIN      = 3'd2,
    CFG_WET_GAIN      = 3'd3,
    CFG_FEEDBACK_GAIN = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic accept;
    logic commit;
  } cmd_t;

endpackage

// ----- src/fdl_ram.sv -----
module fdl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 262144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/fdl_dp.sv -----
module fdl_dp #(
  parameter int unsigned DELAY_DEPTH = 262144
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [fdl_pkg::CFG_IDX_WIDTH-1:0]     cfg_index_i,
  input  logic [fdl_pkg::CFG_WIDTH-1:0]         cfg_data_i,
  input  fdl_pkg::cmd_t                         cmd_i,
  input  logic signed [fdl_pkg::SAMPLE_WIDTH-1:0] sample_in_i,
  output logic signed [fdl_pkg::SAMPLE_WIDTH-1:0] sample_out_o
);

  localparam int unsigned AW = $clog2(DELAY_DEPTH);
  localparam int unsigned FW = $clog2(DELAY_DEPTH + 1);
  localparam int unsigned LW = (FW > fdl_pkg::LEN_WIDTH) ? FW : fdl_pkg::LEN_WIDTH;
  localparam logic [LW-1:0] DepthLen = LW'(DELAY_DEPTH);

  localparam int unsigned SW = fdl_pkg::SAMPLE_WIDTH;
  localparam int unsigned WW = fdl_pkg::WORD_WIDTH;
  localparam int unsigned QS = fdl_pkg::Q_SHIFT;

  logic [fdl_pkg::LEN_WIDTH-1:0]             delay_length_q;
  logic signed [fdl_pkg::PRESCALE_WIDTH-1:0] prescale_q;
  logic signed [fdl_pkg::DRY_WIDTH-1:0]      dry_q;
  logic [fdl_pkg::WET_WIDTH-1:0]             wet_q;
  logic signed [fdl_pkg::FB_WIDTH-1:0]       fb_q;

  logic [AW-1:0] ptr_q, ptr_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          hit_q;
  logic [WW-1:0] scaled_q;
  logic signed [SW-1:0] sample_out_q;

  logic [LW-1:0] len_ext, elen, ptr_inc;
  logic          hit;
  logic [WW-1:0] rd_data;
  logic [WW-1:0] written;
  logic [WW-1:0] sum;

  logic signed [SW+fdl_pkg::PRESCALE_WIDTH-1:0] p_scaled;
  logic signed [SW-1:0]                         half, top;
  logic signed [fdl_pkg::WET_WIDTH:0]           wet_s;
  logic signed [SW+fdl_pkg::DRY_WIDTH-1:0]      p_dry;
  logic signed [SW+fdl_pkg::WET_WIDTH:0]        p_wet;
  logic signed [SW+fdl_pkg::FB_WIDTH-1:0]       p_fb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_length_q <= fdl_pkg::LEN_RESET;
      prescale_q     <= fdl_pkg::PRESCALE_RESET;
      dry_q          <= fdl_pkg::DRY_RESET;
      wet_q          <= fdl_pkg::WET_RESET;
      fb_q           <= fdl_pkg::FB_RESET;
    end else if (cfg_we_i) begin
      unique case (fdl_pkg::cfg_index_e'(cfg_index_i))
        fdl_pkg::CFG_DELAY_LENGTH:  delay_length_q <= cfg_data_i[fdl_pkg::LEN_WIDTH-1:0];
        fdl_pkg::CFG_PRESCALE_GAIN: prescale_q     <= cfg_data_i[fdl_pkg::PRESCALE_WIDTH-1:0];
        fdl_pkg::CFG_DRY_GAIN:      dry_q          <= cfg_data_i[fdl_pkg::DRY_WIDTH-1:0];
        fdl_pkg::CFG_WET_GAIN:      wet_q          <= cfg_data_i[fdl_pkg::WET_WIDTH-1:0];
        fdl_pkg::CFG_FEEDBACK_GAIN: fb_q           <= cfg_data_i[fdl_pkg::FB_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_ext = LW'(delay_length_q);
    priority if (len_ext == '0) begin
      elen = LW'(1);
    end else if (len_ext > DepthLen) begin
      elen = DepthLen;
    end else begin
      elen = len_ext;
    end
    ptr_inc = LW'(ptr_q) + LW'(1);
    ptr_d   = (ptr_inc >= elen) ? '0 : ptr_inc[AW-1:0];
    fill_d  = (FW'(ptr_q) == fill_q) ? fill_q + FW'(1) : fill_q;
  end

  // Words below the fill mark have been written since reset; the rest read as zero.
  assign hit = (FW'(ptr_q) < fill_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      fill_q <= '0;
      hit_q  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        hit_q <= hit;
      end
      if (cmd_i.commit) begin
        ptr_q  <= ptr_d;
        fill_q <= fill_d;
      end
    end
  end

  assign p_scaled = sample_in_i * prescale_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      scaled_q <= p_scaled[WW-1:0];
    end
    if (cmd_i.commit) begin
      sample_out_q <= sum[WW-1:QS];
    end
  end

  fdl_ram #(
    .WIDTH(WW),
    .DEPTH(DELAY_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit),
    .waddr_i(ptr_q),
    .wdata_i(written),
    .re_i   (cmd_i.accept),
    .raddr_i(ptr_q),
    .rdata_o(rd_data)
  );

  assign half  = hit_q ? $signed(rd_data[WW-1:QS]) : '0;
  assign top   = $signed(scaled_q[WW-1:QS]);
  assign wet_s = $signed({1'b0, wet_q});

  assign p_dry = top * dry_q;
  assign p_wet = half * wet_s;
  assign p_fb  = half * fb_q;

  assign sum     = p_dry[WW-1:0] + p_wet[WW-1:0];
  assign written = p_fb[WW-1:0] + scaled_q;

  assign sample_out_o = sample_out_q;

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(ptr_q) < DepthLen)
    else $error("loop pointer beyond store depth");

  a_ptr_within_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FW'(ptr_q) <= fill_q)
    else $error("loop pointer skipped past the fill mark");

endmodule

// ----- src/fdl_ctrl.sv -----
module fdl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output fdl_pkg::cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept, commit;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign commit = (state_q == ST_CALC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_CALC;
      ST_CALC: if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = commit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cmd_o.accept = accept;
  assign cmd_o.commit = commit;

  a_accept_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_CALC)
    else $error("transfer in did not start a computation");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("finished result not presented");

  a_hold_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC && out_valid_q && out_stall_i) |=> state_q == ST_CALC)
    else $error("result dropped while output stalled");

endmodule

// ----- src/feedback_delay_line_q16.sv -----
// Feedback comb delay line on signed 16-bit audio samples, Q16 gains.
// Input channel: in_valid_i / in_stall_o with sample_in_i; a transfer takes
// place on a rising edge with valid high and stall low. Output channel:
// out_valid_o / out_stall_i with sample_out_o, same rule.
// Configuration: write cfg_data_i to register cfg_index_i when cfg_we_i is
// high (0 length, 1 prescale, 2 dry, 3 wet, 4 feedback); write only while
// idle. Stereo runs interleaved through the same path at twice the length.
// The transfer moves the control into its compute state; the result is
// loaded into the output register when that state commits, which a held
// out_stall_i can delay. No new sample is taken before the commit, as the
// delay memory reads in the transfer cycle and writes back at the commit.
// The output register frees the input side: the next sample is taken while
// a result waits; when out_stall_i holds, that next sample waits in the
// compute state and in_stall_o stays high until the output is taken.
// Reset: gains and length return to their defaults, pointer to zero, and
// the store reads as zero through a fill mark, so no clearing pass is needed.
module feedback_delay_line_q16 #(
  parameter int unsigned DELAY_DEPTH = 262144
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [fdl_pkg::CFG_IDX_WIDTH-1:0]       cfg_index_i,
  input  logic [fdl_pkg::CFG_WIDTH-1:0]           cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [fdl_pkg::SAMPLE_WIDTH-1:0] sample_in_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [fdl_pkg::SAMPLE_WIDTH-1:0] sample_out_o
);

  fdl_pkg::cmd_t cmd;

  fdl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  fdl_dp #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sample_in_i (sample_in_i),
    .sample_out_o(sample_out_o)
  );

endmodule
